>>> design/bmpc_pkg.sv
// Package with the beat types and constants of the base-2 modular exponentiation prime check.
`timescale 1ns / 1ps
`default_nettype none
package bmpc_pkg;
   localparam int FIELD_W = 30;

   typedef struct packed {
      logic [FIELD_W-1:0] candidate;
      logic [FIELD_W-1:0] test_exponent;
   } req_beat_type;

   typedef struct packed {
      logic prime_flag;
      logic invalid;
   } rsp_beat_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;
endpackage
`default_nettype wire

>>> design/bmpc_mulmod.sv
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none
module bmpc_mulmod
   import bmpc_pkg::*;
#(
   parameter int WIDTH = FIELD_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] op_a,
   input  wire logic [WIDTH-1:0] op_b,
   input  wire logic [WIDTH-1:0] modulus,
   output mm_status_type         status,
   output logic      [WIDTH-1:0] product
);
   localparam int CW = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH:0]   dbl;
   logic [WIDTH:0]   dbl_red;
   logic [WIDTH:0]   sum;
   logic [WIDTH:0]   sum_red;

   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum     = b_ff[cnt_ff] ? dbl_red + {1'b0, a_ff} : dbl_red;
      sum_red = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH - 1);
         r_in    = '0;
         a_in    = op_a;
         b_in    = op_b;
         m_in    = modulus;
      end else if (busy_ff) begin
         r_in = sum_red[WIDTH-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
   end

   assign status  = '{busy: busy_ff, done: done_ff};
   assign product = r_ff;
endmodule
`default_nettype wire

>>> design/base2_modexp_prime_check.sv
// Top level of the base-2 modular exponentiation prime check with its sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Each beat computes 2^(p-1) mod p and then 2^e mod p by right-to-left square-and-multiply
// on one shared bit-serial modular multiplier. An exponent of k significant bits costs
// up to 2k products, and a candidate below 2 goes straight to an invalid result without
// any product. The second power is skipped when the first is not 1. A new request is
// taken only when the sequencer is idle; the result waits in an output register.
module base2_modexp_prime_check
   import bmpc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_beat_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_beat_type      rsp_data
);
   localparam int WIDTH = FIELD_W;

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_STEP     = 5'b00010,
      S_WAIT_ACC = 5'b00100,
      S_WAIT_SQ  = 5'b01000,
      S_FIN      = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic             phase_ff, phase_in;
   logic             pass_ff, pass_in;
   logic             bad_ff, bad_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] sq_ff, sq_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_beat_type     rsp_ff, rsp_in;
   logic             mm_start;
   logic [WIDTH-1:0] mm_a;
   logic [WIDTH-1:0] mm_b;
   logic [WIDTH-1:0] mm_p;
   mm_status_type    mm_status;
   logic [WIDTH-1:0] cand;
   logic [WIDTH-1:0] two_mod;
   logic [WIDTH-1:0] one_w;

   assign cand    = WIDTH'(req_data.candidate);
   assign one_w   = WIDTH'(1);
   assign two_mod = (m_ff == WIDTH'(2)) ? '0 : WIDTH'(2);

   bmpc_mulmod #(.WIDTH(WIDTH)) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (m_ff),
      .status  (mm_status),
      .product (mm_p)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pass_in      = pass_ff;
      bad_in       = bad_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mm_start     = 1'b0;
      mm_a         = sq_ff;
      mm_b         = sq_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               m_in     = cand;
               e_in     = cand - one_w;
               x_in     = WIDTH'(req_data.test_exponent);
               phase_in = 1'b0;
               pass_in  = 1'b0;
               acc_in   = one_w;
               sq_in    = (cand == WIDTH'(2)) ? '0 : WIDTH'(2);
               bad_in   = (cand < WIDTH'(2));
               state_in = (cand < WIDTH'(2)) ? S_FIN : S_STEP;
            end
         end
         S_STEP: begin
            if (e_ff == '0) begin
               if (!phase_ff && acc_ff == one_w) begin
                  pass_in  = 1'b1;
                  phase_in = 1'b1;
                  e_in     = x_ff;
                  acc_in   = one_w;
                  sq_in    = two_mod;
               end else begin
                  state_in = S_FIN;
               end
            end else if (e_ff[0]) begin
               mm_start = 1'b1;
               mm_a     = acc_ff;
               state_in = S_WAIT_ACC;
            end else begin
               mm_start = 1'b1;
               state_in = S_WAIT_SQ;
            end
         end
         S_WAIT_ACC: begin
            if (mm_status.done) begin
               acc_in   = mm_p;
               mm_start = 1'b1;
               state_in = S_WAIT_SQ;
            end
         end
         S_WAIT_SQ: begin
            if (mm_status.done) begin
               sq_in    = mm_p;
               e_in     = e_ff >> 1;
               state_in = S_STEP;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.invalid    = bad_ff;
               rsp_in.prime_flag = !bad_ff && pass_ff && phase_ff && (acc_ff != one_w);
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff <= phase_in;
      pass_ff  <= pass_in;
      bad_ff   <= bad_in;
      m_ff     <= m_in;
      e_ff     <= e_in;
      x_ff     <= x_in;
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
      rsp_ff   <= rsp_in;
   end

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      mm_status.busy |-> !mm_start)
      else $error("Multiplier started while busy.");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mm_status.busy)
      else $error("Multiplier busy while sequencer idle.");
   a_invalid_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.invalid) |-> !rsp_ff.prime_flag)
      else $error("Prime verdict on invalid candidate.");
   a_wait_busy: assert property (@(posedge clock) disable iff (reset)
      ($past(mm_start) && !$past(reset)) |-> mm_status.busy)
      else $error("Multiplier did not start.");
`endif
endmodule
`default_nettype wire
